// File: hdl/pal_pkg.sv
package pal_pkg;

    // Fixed field widths of the request and result channels
    localparam int OP_W    = 3;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 6;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
    localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd2;
    localparam logic [OP_W-1:0] OP_REPLACE  = 3'd3;
    localparam logic [OP_W-1:0] OP_TRAVERSE = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;

    // Commands from controller to datapath
    typedef struct packed {
        logic do_insert;
        logic do_delete;
        logic do_replace;
        logic do_clear;
        logic emit;
        logic emit_read;
        logic emit_err;
        logic emit_last;
        logic rd_trav;
        logic trav_start;
        logic trav_step;
    } pal_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic pos_le_fill;
        logic pos_lt_fill;
        logic full;
        logic empty;
        logic out_free;
        logic trav_last;
    } pal_status_t;

endpackage

// File: hdl/pal_ctrl.sv
module pal_ctrl
    import pal_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   op,
    input  pal_status_t       status,
    output pal_cmd_t          cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TRAV = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    // New request only when idle and the result register can take a result
    assign in_stall = (state_reg != ST_IDLE) || !status.out_free;
    assign accept   = in_valid && !in_stall;

    // Decode and sequencing
    always_comb
    begin
        cmd           = '0;
        cmd.emit_last = 1'b1;
        state_next    = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_INSERT:
                        begin
                            cmd.emit      = 1'b1;
                            cmd.do_insert = !status.full && status.pos_le_fill;
                            cmd.emit_err  = status.full || !status.pos_le_fill;
                        end
                        OP_DELETE:
                        begin
                            cmd.emit      = 1'b1;
                            cmd.do_delete = status.pos_lt_fill;
                            cmd.emit_read = status.pos_lt_fill;
                            cmd.emit_err  = !status.pos_lt_fill;
                        end
                        OP_RETRIEVE:
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_read = status.pos_lt_fill;
                            cmd.emit_err  = !status.pos_lt_fill;
                        end
                        OP_REPLACE:
                        begin
                            cmd.emit       = 1'b1;
                            cmd.do_replace = status.pos_lt_fill;
                            cmd.emit_err   = !status.pos_lt_fill;
                        end
                        OP_TRAVERSE:
                        begin
                            if (status.empty)
                            begin
                                cmd.emit = 1'b1;
                            end
                            else
                            begin
                                cmd.trav_start = 1'b1;
                                state_next     = ST_TRAV;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cmd.emit     = 1'b1;
                            cmd.do_clear = 1'b1;
                        end
                        default:
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_err = 1'b1;
                        end
                    endcase
                end
            end
            ST_TRAV:
            begin
                // One entry per free output slot
                cmd.rd_trav = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_read = 1'b1;
                    cmd.emit_last = status.trav_last;
                    cmd.trav_step = 1'b1;
                    if (status.trav_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/pal_datapath.sv
module pal_datapath
    import pal_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pal_cmd_t           cmd,
    output pal_status_t        status,
    input  logic [POS_W-1:0]   position,
    input  logic [WIDTH-1:0]   value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [WIDTH-1:0]   data,
    output logic               data_valid,
    output logic               last,
    output logic               error,
    output logic [COUNT_W-1:0] count,
    output logic               is_empty,
    output logic               is_full
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = ((FW > POS_W) ? FW : POS_W) + 1;

    logic [WIDTH-1:0]   entries_reg [DEPTH];
    logic [FW-1:0]      fill_reg;
    logic [FW-1:0]      fill_next;
    logic [IW-1:0]      idx_reg;
    logic [CW-1:0]      pos_ext;
    logic [CW-1:0]      fill_ext;
    logic [IW-1:0]      rd_addr;
    logic [WIDTH-1:0]   rd_data;

    logic               out_valid_reg;
    logic [WIDTH-1:0]   data_reg;
    logic               data_valid_reg;
    logic               last_reg;
    logic               error_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               is_empty_reg;
    logic               is_full_reg;

    // Position and fill comparisons
    assign pos_ext  = CW'(position);
    assign fill_ext = CW'(fill_reg);

    assign status.pos_le_fill = pos_ext <= fill_ext;
    assign status.pos_lt_fill = pos_ext < fill_ext;
    assign status.full        = fill_reg == FW'(DEPTH);
    assign status.empty       = fill_reg == '0;
    assign status.out_free    = !out_valid_reg || !out_stall;
    assign status.trav_last   = (CW'(idx_reg) + CW'(1)) == fill_ext;

    // Read port: addressed entry or traverse index
    assign rd_addr = cmd.rd_trav ? idx_reg : position[IW-1:0];
    assign rd_data = entries_reg[rd_addr];

    // Fill level after the operation
    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.do_clear)
        begin
            fill_next = '0;
        end
        else if (cmd.do_insert)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (cmd.do_delete)
        begin
            fill_next = fill_reg - FW'(1);
        end
    end

    // Entry cells: each compares its index with the position
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cmd.do_insert)
            begin
                if (CW'(i) == pos_ext)
                begin
                    entries_reg[i] <= value;
                end
                else if (CW'(i) > pos_ext && i > 0)
                begin
                    entries_reg[i] <= entries_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (cmd.do_delete)
            begin
                if (CW'(i) >= pos_ext && i < DEPTH - 1)
                begin
                    entries_reg[i] <= entries_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
            else if (cmd.do_replace)
            begin
                if (CW'(i) == pos_ext)
                begin
                    entries_reg[i] <= value;
                end
            end
        end
    end

    // Fill level and traverse index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cmd.trav_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.trav_step)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            data_reg       <= cmd.emit_read ? rd_data : '0;
            data_valid_reg <= cmd.emit_read;
            last_reg       <= cmd.emit_last;
            error_reg      <= cmd.emit_err;
            count_reg      <= COUNT_W'(fill_next);
            is_empty_reg   <= fill_next == '0;
            is_full_reg    <= fill_next == FW'(DEPTH);
        end
    end

    assign out_valid  = out_valid_reg;
    assign data       = data_reg;
    assign data_valid = data_valid_reg;
    assign last       = last_reg;
    assign error      = error_reg;
    assign count      = count_reg;
    assign is_empty   = is_empty_reg;
    assign is_full    = is_full_reg;

endmodule

// File: hdl/positional_array_list.sv
// Bounded ordered list of up to DEPTH words. Each request carries an op:
// insert at a position (later entries move up), delete at a position (later
// entries move down, removed word returned), retrieve, replace, traverse
// (every entry from position 0 upward, the final one marked last) or clear.
// Every result reports count, is_empty and is_full after the operation;
// out-of-range positions, insert into a full list, delete from an empty
// list and unknown ops return error and change nothing. Timing: a request
// is taken when no traverse is running and the result register is free;
// all ops except traverse are done when taken (one request per cycle with
// the result side ready). The entries sit in a row of registers whose cells
// all shift in the same cycle, so insert and delete cost no more than a
// retrieve. A traverse enters its traverse state, then gives one entry per
// cycle through the single read port while the result register is free; an
// empty traverse gives one result with no data. No clearing pass after reset.
module positional_array_list
    import pal_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [OP_W-1:0]    op,
    input  logic [POS_W-1:0]   position,
    input  logic [WIDTH-1:0]   value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [WIDTH-1:0]   data,
    output logic               data_valid,
    output logic               last,
    output logic               error,
    output logic [COUNT_W-1:0] count,
    output logic               is_empty,
    output logic               is_full
);

    pal_cmd_t    cmd;
    pal_status_t status;

    pal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .status   (status),
        .cmd      (cmd)
    );

    pal_datapath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data       (data),
        .data_valid (data_valid),
        .last       (last),
        .error      (error),
        .count      (count),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

endmodule
